// ===== src/sampled_values_frame_parser_defines.svh =====
// Assertion macros for the sampled values frame parser checker.
// Used by svfp_checker; no other dependencies.
`ifndef SAMPLED_VALUES_FRAME_PARSER_DEFINES_SVH
`define SAMPLED_VALUES_FRAME_PARSER_DEFINES_SVH

// Implication checked in the same cycle.
`define SVFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SVFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/svfp_pkg.sv =====
// Shared types, field codes and 9-1 layout tables of the frame parser.
// No dependencies.
`default_nettype none
package svfp_pkg;

  localparam int MaxFrame = 2048;
  localparam int OffW     = $clog2(MaxFrame);
  localparam int FoW      = OffW + 1;
  localparam int EndW     = 17;
  localparam int Slots91  = 25;

  // Field codes.
  localparam logic [5:0] FC_DST      = 6'd0;
  localparam logic [5:0] FC_SRC      = 6'd1;
  localparam logic [5:0] FC_ETYPE    = 6'd2;
  localparam logic [5:0] FC_VLAN     = 6'd3;
  localparam logic [5:0] FC_ETYPE2   = 6'd4;
  localparam logic [5:0] FC_APPID    = 6'd5;
  localparam logic [5:0] FC_LENGTH   = 6'd6;
  localparam logic [5:0] FC_RES1     = 6'd7;
  localparam logic [5:0] FC_RES2     = 6'd8;
  localparam logic [5:0] FC_UNK_FRM  = 6'd9;
  localparam logic [5:0] FC_PDU91    = 6'd10;
  localparam logic [5:0] FC_PDU92    = 6'd11;
  localparam logic [5:0] FC_UNK_PDU  = 6'd12;
  localparam logic [5:0] FC_NOASDU91 = 6'd13;
  localparam logic [5:0] FC_NOASDU92 = 6'd28;
  localparam logic [5:0] FC_SEQ      = 6'd29;
  localparam logic [5:0] FC_ASDU     = 6'd30;
  localparam logic [5:0] FC_SVID     = 6'd31;
  localparam logic [5:0] FC_SEQDATA  = 6'd38;
  localparam logic [5:0] FC_SMPVAL   = 6'd39;
  localparam logic [5:0] FC_SMPQUAL  = 6'd40;
  localparam logic [5:0] FC_UNK_ITEM = 6'd41;
  localparam logic [5:0] FC_END      = 6'd48;

  localparam logic [7:0] TAG_PDU91 = 8'h80;
  localparam logic [7:0] TAG_PDU92 = 8'h60;
  localparam logic [7:0] TAG_SEQDT = 8'h87;
  localparam logic [7:0] TAG_ITLO  = 8'h80;
  localparam logic [7:0] TAG_ITHI  = 8'h86;
  localparam logic [15:0] ET_VLAN  = 16'h8100;
  localparam logic [15:0] ET_SV    = 16'h88BA;

  typedef struct packed {
    logic [5:0]      code;
    logic [47:0]     value;
    logic [OffW-1:0] offset;
    logic [15:0]     length;
    logic [15:0]     asdu;
    logic [7:0]      chan;
    logic            frame_end;
  } rec_t;

  function automatic rec_t mk_rec(logic [5:0] code, logic [47:0] value,
                                  logic [OffW-1:0] offset, logic [15:0] length,
                                  logic [15:0] asdu, logic [7:0] chan);
    rec_t r;
    r.code      = code;
    r.value     = value;
    r.offset    = offset;
    r.length    = length;
    r.asdu      = asdu;
    r.chan      = chan;
    r.frame_end = 1'b0;
    return r;
  endfunction

  // Field code of each slot of a 9-1 ASDU.
  function automatic logic [5:0] slot_code(logic [4:0] s);
    logic [5:0] c;
    if (s < 5'd8) c = 6'd14 + {1'b0, s};
    else if (s < 5'd20) c = 6'd22;
    else c = 6'd3 + {1'b0, s};
    return c;
  endfunction

  // Byte size of each slot of a 9-1 ASDU.
  function automatic logic [15:0] slot_size(logic [4:0] s);
    logic [15:0] z;
    if (s == 5'd1 || s == 5'd2 || s == 5'd23 || s == 5'd24) z = 16'd1;
    else z = 16'd2;
    return z;
  endfunction

endpackage
`default_nettype wire

// ===== src/sampled_values_frame_parser.sv =====
// Sampled values frame parser: takes one frame byte per cycle while in_stall is low and issues one
// record per decoded field, plus an end record on the final byte. Every byte
// is parsed in the cycle it is accepted, so a byte can be taken every cycle.
// Records wait in a four-entry output queue; in_stall rises while fewer than
// two entries are free, since the final byte of a frame may yield two records
// (its own field and the end of frame). With the output side taking a record
// each cycle, the sustained rate is one byte per cycle.
// Depends on svfp_pkg.
`default_nettype none
module sampled_values_frame_parser (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [7:0]               in_data_byte,
  input  wire                      in_last,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [5:0]               out_field_code,
  output logic [47:0]              out_value,
  output logic [svfp_pkg::OffW-1:0] out_byte_offset,
  output logic [15:0]              out_field_length,
  output logic [15:0]              out_asdu_index,
  output logic [7:0]               out_channel_index,
  output logic                     out_frame_end
);
  import svfp_pkg::*;

  typedef enum logic [4:0] {
    PH_DST, PH_SRC, PH_ETYPE, PH_VLAN, PH_ETYPE2, PH_APPID, PH_LENGTH,
    PH_RES1, PH_RES2, PH_NOASDU91, PH_ASDU91, PH_CHVAL, PH_CHQUAL,
    PH_PDU_TAG, PH_TAG, PH_LEN1, PH_LENX, PH_ITEMVAL, PH_SKIP, PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    K_PDU91, K_PDU92, K_NOASDU, K_SEQ, K_ASDU, K_ITEM
  } kind_t;

  phase_t          phase_r, phase_nxt;
  kind_t           kind_r, kind_nxt;
  logic [FoW-1:0]  fo_r, fo_nxt;
  logic [15:0]     fbc_r, fbc_nxt;
  logic [OffW-1:0] fstart_r, fstart_nxt;
  logic [15:0]     ftotal_r, ftotal_nxt;
  logic [47:0]     vshift_r, vshift_nxt;
  logic [6:0]      lbl_r, lbl_nxt;
  logic [7:0]      tag_r, tag_nxt;
  logic [15:0]     atotal_r, atotal_nxt;
  logic [15:0]     adone_r, adone_nxt;
  logic [EndW-1:0] aend_r, aend_nxt;
  logic [7:0]      ccnt_r, ccnt_nxt;
  logic [6:0]      lform_r, lform_nxt;
  logic [7:0]      hdr_r, hdr_nxt;
  logic [4:0]      slot_r, slot_nxt;
  logic [15:0]     cleft_r, cleft_nxt;
  logic [EndW-1:0] iend_r, iend_nxt;
  logic [15:0]     rlen_r, rlen_nxt;

  logic            accept;
  logic            rec_a_v, rec_b_v;
  rec_t            rec_a, rec_b;

  // Output queue.
  rec_t            q_mem [4];
  logic [1:0]      wp_r, rp_r;
  logic [2:0]      cnt_r;
  logic            pop;

  assign in_stall = (cnt_r > 3'd2);
  assign accept   = in_valid && !in_stall;

  // Parse one byte: the phase step, then the follow-up actions in order.
  always_comb begin
    logic [OffW-1:0] off;
    logic [EndW-1:0] off1;
    logic [47:0]     v;
    logic [4:0]      s;
    logic            do_len, do_fixed, do_ival, do_after, do_ifin, do_afin, do_next;

    phase_nxt  = phase_r;   kind_nxt   = kind_r;   fo_nxt     = fo_r;
    fbc_nxt    = fbc_r;     fstart_nxt = fstart_r; ftotal_nxt = ftotal_r;
    vshift_nxt = vshift_r;  lbl_nxt    = lbl_r;    tag_nxt    = tag_r;
    atotal_nxt = atotal_r;  adone_nxt  = adone_r;  aend_nxt   = aend_r;
    ccnt_nxt   = ccnt_r;    lform_nxt  = lform_r;  hdr_nxt    = hdr_r;
    slot_nxt   = slot_r;    cleft_nxt  = cleft_r;  iend_nxt   = iend_r;
    rlen_nxt   = rlen_r;
    rec_a_v = 1'b0; rec_a = '0; rec_b_v = 1'b0; rec_b = '0;
    do_len = 1'b0; do_fixed = 1'b0; do_ival = 1'b0; do_after = 1'b0;
    do_ifin = 1'b0; do_afin = 1'b0; do_next = 1'b0;
    off  = fo_r[OffW-1:0];
    off1 = EndW'(off) + EndW'(1);
    v    = '0;
    s    = '0;

    if (accept && fo_r < FoW'(MaxFrame)) begin
      // Per-phase byte handling.
      case (phase_r)
        PH_PDU_TAG: begin
          fstart_nxt = off;
          tag_nxt = in_data_byte;
          if (in_data_byte == TAG_PDU91) begin
            kind_nxt = K_PDU91; phase_nxt = PH_LEN1;
          end else if (in_data_byte == TAG_PDU92) begin
            kind_nxt = K_PDU92; phase_nxt = PH_LEN1;
          end else begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_UNK_PDU, 48'(in_data_byte), off, 16'd1, '0, '0);
            phase_nxt = PH_IDLE;
          end
        end
        PH_TAG: begin
          fstart_nxt = off;
          tag_nxt = in_data_byte;
          phase_nxt = PH_LEN1;
        end
        PH_LEN1: begin
          ftotal_nxt = '0;
          if (in_data_byte[7]) begin
            lform_nxt = in_data_byte[6:0];
            hdr_nxt = 8'd2 + 8'(in_data_byte[6:0]);
            if (in_data_byte[6:0] == '0) do_len = 1'b1;
            else begin
              lbl_nxt = in_data_byte[6:0];
              phase_nxt = PH_LENX;
            end
          end else begin
            ftotal_nxt = 16'(in_data_byte);
            hdr_nxt = 8'd2;
            do_len = 1'b1;
          end
        end
        PH_LENX: begin
          if (lform_r == 7'd1 || lform_r == 7'd2)
            ftotal_nxt = {ftotal_r[7:0], in_data_byte};
          if (lbl_r != '0) lbl_nxt = lbl_r - 7'd1;
          if (lbl_nxt == '0) do_len = 1'b1;
        end
        PH_ITEMVAL: begin
          vshift_nxt = {vshift_r[39:0], in_data_byte};
          fbc_nxt = fbc_r + 16'd1;
          if (fbc_nxt >= ftotal_r) do_ival = 1'b1;
        end
        PH_SKIP: begin
          if (off1 >= iend_r) do_ifin = 1'b1;
        end
        PH_IDLE: ;
        default: begin
          if (fbc_r == '0) fstart_nxt = off;
          vshift_nxt = {vshift_r[39:0], in_data_byte};
          fbc_nxt = fbc_r + 16'd1;
          if (fbc_nxt >= ftotal_r) do_fixed = 1'b1;
        end
      endcase

      // A length field has completed.
      if (do_len) begin
        rlen_nxt = 16'(hdr_nxt) + ftotal_nxt;
        case (kind_nxt)
          K_PDU91: begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_PDU91, 48'(ftotal_nxt), fstart_nxt, rlen_nxt, '0, '0);
            phase_nxt = PH_NOASDU91; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
          end
          K_PDU92: begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_PDU92, 48'(ftotal_nxt), fstart_nxt, rlen_nxt, '0, '0);
            kind_nxt = K_NOASDU; phase_nxt = PH_TAG;
          end
          K_SEQ: begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_SEQ, 48'(ftotal_nxt), fstart_nxt, rlen_nxt, '0, '0);
            adone_nxt = '0;
            do_next = 1'b1;
          end
          K_ASDU: begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_ASDU, 48'(ftotal_nxt), fstart_nxt, rlen_nxt, adone_r, '0);
            aend_nxt = off1 + EndW'(ftotal_nxt);
            if (ftotal_nxt == '0) do_afin = 1'b1;
            else begin
              kind_nxt = K_ITEM; phase_nxt = PH_TAG;
            end
          end
          default: begin
            iend_nxt = off1 + EndW'(ftotal_nxt);
            if (kind_nxt == K_ITEM && tag_r == TAG_SEQDT) begin
              cleft_nxt = {3'b000, ftotal_nxt[15:3]};
              rec_a_v = 1'b1;
              rec_a = mk_rec(FC_SEQDATA, 48'(cleft_nxt), fstart_nxt, rlen_nxt,
                             adone_r, '0);
              ccnt_nxt = '0;
              if (cleft_nxt != '0) begin
                phase_nxt = PH_CHVAL; ftotal_nxt = 16'd4; fbc_nxt = '0; vshift_nxt = '0;
              end else do_after = 1'b1;
            end else if (ftotal_nxt == '0) begin
              vshift_nxt = '0;
              do_ival = 1'b1;
            end else begin
              fbc_nxt = '0; vshift_nxt = '0; phase_nxt = PH_ITEMVAL;
            end
          end
        endcase
      end

      // A fixed-size field has completed.
      if (do_fixed) begin
        v = vshift_nxt;
        case (phase_r)
          PH_DST: begin
            rec_a_v = 1'b1; rec_a = mk_rec(FC_DST, v, fstart_nxt, ftotal_r, '0, '0);
            phase_nxt = PH_SRC; ftotal_nxt = 16'd6; fbc_nxt = '0; vshift_nxt = '0;
          end
          PH_SRC: begin
            rec_a_v = 1'b1; rec_a = mk_rec(FC_SRC, v, fstart_nxt, ftotal_r, '0, '0);
            phase_nxt = PH_ETYPE; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
          end
          PH_ETYPE: begin
            rec_a_v = 1'b1;
            if (v == 48'(ET_VLAN)) begin
              rec_a = mk_rec(FC_ETYPE, v, fstart_nxt, ftotal_r, '0, '0);
              phase_nxt = PH_VLAN; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
            end else if (v == 48'(ET_SV)) begin
              rec_a = mk_rec(FC_ETYPE, v, fstart_nxt, ftotal_r, '0, '0);
              phase_nxt = PH_APPID; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
            end else begin
              rec_a = mk_rec(FC_UNK_FRM, v, fstart_nxt, ftotal_r, '0, '0);
              phase_nxt = PH_IDLE;
            end
          end
          PH_VLAN: begin
            rec_a_v = 1'b1; rec_a = mk_rec(FC_VLAN, v, fstart_nxt, ftotal_r, '0, '0);
            phase_nxt = PH_ETYPE2; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
          end
          PH_ETYPE2: begin
            rec_a_v = 1'b1;
            if (v == 48'(ET_SV)) begin
              rec_a = mk_rec(FC_ETYPE2, v, fstart_nxt, ftotal_r, '0, '0);
              phase_nxt = PH_APPID; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
            end else begin
              rec_a = mk_rec(FC_UNK_FRM, v, fstart_nxt, ftotal_r, '0, '0);
              phase_nxt = PH_IDLE;
            end
          end
          PH_APPID: begin
            rec_a_v = 1'b1; rec_a = mk_rec(FC_APPID, v, fstart_nxt, ftotal_r, '0, '0);
            phase_nxt = PH_LENGTH; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
          end
          PH_LENGTH: begin
            rec_a_v = 1'b1; rec_a = mk_rec(FC_LENGTH, v, fstart_nxt, ftotal_r, '0, '0);
            phase_nxt = PH_RES1; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
          end
          PH_RES1: begin
            rec_a_v = 1'b1; rec_a = mk_rec(FC_RES1, v, fstart_nxt, ftotal_r, '0, '0);
            phase_nxt = PH_RES2; ftotal_nxt = 16'd2; fbc_nxt = '0; vshift_nxt = '0;
          end
          PH_RES2: begin
            rec_a_v = 1'b1; rec_a = mk_rec(FC_RES2, v, fstart_nxt, ftotal_r, '0, '0);
            phase_nxt = PH_PDU_TAG;
          end
          PH_NOASDU91: begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_NOASDU91, v, fstart_nxt, ftotal_r, '0, '0);
            atotal_nxt = v[15:0];
            adone_nxt = '0;
            slot_nxt = '0;
            if (v[15:0] == '0) phase_nxt = PH_IDLE;
            else begin
              phase_nxt = PH_ASDU91; ftotal_nxt = slot_size('0);
              fbc_nxt = '0; vshift_nxt = '0;
            end
          end
          PH_ASDU91: begin
            s = (slot_r >= 5'(Slots91)) ? '0 : slot_r;
            rec_a_v = 1'b1;
            rec_a = mk_rec(slot_code(s), v, fstart_nxt, ftotal_r, adone_r,
                           (s >= 5'd8 && s < 5'd20) ? 8'(s - 5'd8) : 8'd0);
            s = s + 5'd1;
            if (s >= 5'(Slots91)) begin
              s = '0;
              adone_nxt = adone_r + 16'd1;
            end
            slot_nxt = s;
            if (s == '0 && adone_nxt >= atotal_r) phase_nxt = PH_IDLE;
            else begin
              phase_nxt = PH_ASDU91; ftotal_nxt = slot_size(s);
              fbc_nxt = '0; vshift_nxt = '0;
            end
          end
          PH_CHVAL: begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_SMPVAL, v, fstart_nxt, ftotal_r, adone_r, ccnt_r);
            phase_nxt = PH_CHQUAL; ftotal_nxt = 16'd4; fbc_nxt = '0; vshift_nxt = '0;
          end
          default: begin
            rec_a_v = 1'b1;
            rec_a = mk_rec(FC_SMPQUAL, v, fstart_nxt, ftotal_r, adone_r, ccnt_r);
            ccnt_nxt = ccnt_r + 8'd1;
            if (cleft_r != '0) cleft_nxt = cleft_r - 16'd1;
            if (cleft_nxt != '0) begin
              phase_nxt = PH_CHVAL; ftotal_nxt = 16'd4; fbc_nxt = '0; vshift_nxt = '0;
            end else do_after = 1'b1;
          end
        endcase
      end

      // An item value has completed.
      if (do_ival) begin
        v = (ftotal_nxt <= 16'd4) ? vshift_nxt : '0;
        rec_a_v = 1'b1;
        if (kind_nxt == K_NOASDU) begin
          rec_a = mk_rec(FC_NOASDU92, v, fstart_nxt, rlen_nxt, '0, '0);
          atotal_nxt = v[15:0];
          kind_nxt = K_SEQ;
          phase_nxt = PH_TAG;
        end else begin
          if (tag_r >= TAG_ITLO && tag_r <= TAG_ITHI)
            rec_a = mk_rec(FC_SVID + 6'(tag_r - TAG_ITLO), v, fstart_nxt, rlen_nxt,
                           adone_r, '0);
          else
            rec_a = mk_rec(FC_UNK_ITEM, 48'(tag_r), fstart_nxt, rlen_nxt, adone_r, '0);
          do_ifin = 1'b1;
        end
      end

      // Sample channels are done; skip any leftover bytes of the item.
      if (do_after) begin
        if (off1 < iend_nxt) phase_nxt = PH_SKIP;
        else do_ifin = 1'b1;
      end

      // An item is done: next item or end of its ASDU.
      if (do_ifin) begin
        if (off1 < aend_nxt) begin
          kind_nxt = K_ITEM; phase_nxt = PH_TAG;
        end else do_afin = 1'b1;
      end

      if (do_afin) begin
        adone_nxt = adone_nxt + 16'd1;
        do_next = 1'b1;
      end

      if (do_next) begin
        if (adone_nxt < atotal_nxt) begin
          kind_nxt = K_ASDU; phase_nxt = PH_TAG;
        end else phase_nxt = PH_IDLE;
      end

      fo_nxt = fo_r + FoW'(1);
    end

    // Final byte: end record and return to the start of a frame.
    if (accept && in_last) begin
      rec_b_v = 1'b1;
      rec_b = mk_rec(FC_END, 48'(fo_nxt), OffW'(fo_nxt - FoW'(1)), '0, '0, '0);
      rec_b.frame_end = 1'b1;
      phase_nxt = PH_DST;  kind_nxt  = K_PDU91; fo_nxt    = '0;
      fbc_nxt   = '0;      fstart_nxt = '0;     ftotal_nxt = 16'd6;
      vshift_nxt = '0;     lbl_nxt   = '0;      tag_nxt   = '0;
      atotal_nxt = '0;     adone_nxt = '0;      aend_nxt  = '0;
      ccnt_nxt  = '0;      lform_nxt = '0;      hdr_nxt   = '0;
      slot_nxt  = '0;      cleft_nxt = '0;      iend_nxt  = '0;
      rlen_nxt  = '0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DST;  kind_r  <= K_PDU91; fo_r     <= '0;
      fbc_r   <= '0;      fstart_r <= '0;     ftotal_r <= 16'd6;
      vshift_r <= '0;     lbl_r   <= '0;      tag_r    <= '0;
      atotal_r <= '0;     adone_r <= '0;      aend_r   <= '0;
      ccnt_r  <= '0;      lform_r <= '0;      hdr_r    <= '0;
      slot_r  <= '0;      cleft_r <= '0;      iend_r   <= '0;
      rlen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;  kind_r  <= kind_nxt;   fo_r     <= fo_nxt;
      fbc_r   <= fbc_nxt;    fstart_r <= fstart_nxt; ftotal_r <= ftotal_nxt;
      vshift_r <= vshift_nxt; lbl_r  <= lbl_nxt;    tag_r    <= tag_nxt;
      atotal_r <= atotal_nxt; adone_r <= adone_nxt; aend_r   <= aend_nxt;
      ccnt_r  <= ccnt_nxt;   lform_r <= lform_nxt;  hdr_r    <= hdr_nxt;
      slot_r  <= slot_nxt;   cleft_r <= cleft_nxt;  iend_r   <= iend_nxt;
      rlen_r  <= rlen_nxt;
    end
  end

  // Output queue storage: the first record of a byte, then the end record.
  always_ff @(posedge clk) begin
    if (rec_a_v) q_mem[wp_r] <= rec_a;
    if (rec_b_v) begin
      if (rec_a_v) q_mem[wp_r + 2'd1] <= rec_b;
      else q_mem[wp_r] <= rec_b;
    end
  end

  assign pop = out_valid && !out_stall;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + 2'(rec_a_v) + 2'(rec_b_v);
      rp_r  <= rp_r + 2'(pop);
      cnt_r <= cnt_r + 3'(rec_a_v) + 3'(rec_b_v) - 3'(pop);
    end
  end

  assign out_valid         = (cnt_r != '0);
  assign out_field_code    = q_mem[rp_r].code;
  assign out_value         = q_mem[rp_r].value;
  assign out_byte_offset   = q_mem[rp_r].offset;
  assign out_field_length  = q_mem[rp_r].length;
  assign out_asdu_index    = q_mem[rp_r].asdu;
  assign out_channel_index = q_mem[rp_r].chan;
  assign out_frame_end     = q_mem[rp_r].frame_end;

endmodule
`default_nettype wire

// ===== src/svfp_checker.sv =====
// Port-level checks for the sampled values frame parser, bound to its top.
// Depends on svfp_pkg and sampled_values_frame_parser_defines.svh.
`default_nettype none
`include "sampled_values_frame_parser_defines.svh"
module svfp_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_stall,
  input wire                       in_last,
  input wire                       out_valid,
  input wire                       out_stall,
  input wire [5:0]                 out_field_code,
  input wire [47:0]                out_value,
  input wire [15:0]                out_field_length,
  input wire                       out_frame_end
);
  import svfp_pkg::*;

  // A stalled record holds still.
  `SVFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_field_code), "stalled record changed")

  // The frame end flag marks exactly the end record.
  `SVFP_ASSERT_NOW(a_end_code, out_valid, out_frame_end == (out_field_code == FC_END), "frame end flag and code disagree")

  // An end record never counts zero bytes and has no length.
  `SVFP_ASSERT_NOW(a_end_len, out_valid && out_frame_end, out_field_length == '0 && out_value != '0, "bad end record")

  // A final byte taken always leaves a record to deliver.
  `SVFP_ASSERT_NEXT(a_last_out, in_valid && !in_stall && in_last, out_valid, "no record after final byte")

endmodule

bind sampled_values_frame_parser svfp_checker u_svfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_field_code   (out_field_code),
  .out_value        (out_value),
  .out_field_length (out_field_length),
  .out_frame_end    (out_frame_end)
);
`default_nettype wire
